// ===== rtl/core/trd_pkg.sv =====
`default_nettype none
package trd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned TotalW  = 32;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 32;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_HAS_ALPHA   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PIXEL_TOTAL = 2'd1;

	// Byte position inside a pixel.
	localparam logic [1:0] POS_BLUE  = 2'd0;
	localparam logic [1:0] POS_GREEN = 2'd1;
	localparam logic [1:0] POS_RED   = 2'd2;
	localparam logic [1:0] POS_ALPHA = 2'd3;

	localparam logic [ByteW-1:0] MaxRepeat = 8'd128;

	typedef struct packed {
		logic [ByteW-1:0] blue;
		logic [ByteW-1:0] green;
		logic [ByteW-1:0] red;
		logic [ByteW-1:0] alpha;
		logic [ByteW-1:0] repeat_count;
		logic             image_done;
	} pix_t;

endpackage
`default_nettype wire

// ===== rtl/core/trd_front.sv =====
`default_nettype none
module trd_front
	import trd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_vld,
	input  wire logic [ByteW-1:0]   byte_in,
	input  wire logic               wr_en,
	input  wire logic [CfgIdxW-1:0] wr_index,
	input  wire logic [CfgW-1:0]    wr_data,
	output logic                    pix_vld,
	output pix_t                    pix
);

	logic                has_alpha_q;
	logic [TotalW-1:0]   pixel_total_q;
	logic                hdr_q;
	logic                run_q;
	logic [ByteW-1:0]    rem_q;
	logic [1:0]          pos_q;
	logic [23:0]         held_q;
	logic [TotalW-1:0]   emitted_q;

	logic                last_byte;
	logic [TotalW:0]     diff;
	logic                total_ahead;
	logic [TotalW-1:0]   left;
	logic                left_small;
	logic [ByteW-1:0]    count_raw;
	logic [ByteW-1:0]    count;
	logic                done;
	logic [ByteW-1:0]    rem_dec;

	always_comb begin
		last_byte = (pos_q == POS_ALPHA) || ((pos_q == POS_RED) && !has_alpha_q);

		// One subtractor gives both the pixels left and whether any are left.
		diff        = {1'b0, pixel_total_q} - {1'b0, emitted_q};
		total_ahead = !diff[TotalW] && (diff[TotalW-1:0] != '0);
		left        = total_ahead ? diff[TotalW-1:0] : TotalW'(1);
		left_small  = (left[TotalW-1:ByteW] == '0);

		count_raw = run_q ? rem_q : 8'd1;
		if ((count_raw == '0) || (count_raw > MaxRepeat)) begin
			count_raw = 8'd1;
		end
		// Clip the last run to what the image still needs.
		if (left_small && (left[ByteW-1:0] < count_raw)) begin
			count = left[ByteW-1:0];
		end else begin
			count = count_raw;
		end
		done = left_small && (left[ByteW-1:0] == count);

		rem_dec = (rem_q != '0) ? rem_q - 8'd1 : '0;

		pix_vld          = byte_vld && !hdr_q && last_byte;
		pix.blue         = held_q[7:0];
		pix.green        = held_q[15:8];
		pix.red          = (pos_q == POS_RED) ? byte_in : held_q[23:16];
		pix.alpha        = ((pos_q == POS_ALPHA) && has_alpha_q) ? byte_in : '0;
		pix.repeat_count = count;
		pix.image_done   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_alpha_q   <= 1'b0;
			pixel_total_q <= TotalW'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_HAS_ALPHA:   has_alpha_q   <= wr_data[0];
				REG_PIXEL_TOTAL: pixel_total_q <= wr_data[TotalW-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q     <= 1'b1;
			run_q     <= 1'b0;
			rem_q     <= '0;
			pos_q     <= POS_BLUE;
			emitted_q <= '0;
		end else if (byte_vld) begin
			if (hdr_q) begin
				run_q <= byte_in[7];
				rem_q <= {1'b0, byte_in[6:0]} + 8'd1;
				hdr_q <= 1'b0;
				pos_q <= POS_BLUE;
			end else if (!last_byte) begin
				pos_q <= pos_q + 2'd1;
			end else if (done) begin
				// The image is complete; the next byte opens a new image.
				hdr_q     <= 1'b1;
				run_q     <= 1'b0;
				rem_q     <= '0;
				pos_q     <= POS_BLUE;
				emitted_q <= '0;
			end else begin
				pos_q     <= POS_BLUE;
				emitted_q <= emitted_q + TotalW'(count);
				if (run_q) begin
					rem_q <= '0;
					hdr_q <= 1'b1;
				end else begin
					rem_q <= rem_dec;
					if (rem_dec == '0) begin
						hdr_q <= 1'b1;
					end
				end
			end
		end
	end

	// Colour bytes are held until the pixel completes.
	always_ff @(posedge clk) begin
		if (byte_vld && !hdr_q && !last_byte) begin
			case (pos_q)
				POS_BLUE:  held_q[7:0]   <= byte_in;
				POS_GREEN: held_q[15:8]  <= byte_in;
				POS_RED:   held_q[23:16] <= byte_in;
				default:   ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/trd_queue.sv =====
`default_nettype none
module trd_queue
	import trd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_vld,
	input  wire pix_t wr_pix,
	input  wire logic rd_en,
	output logic      q_empty,
	output logic      q_full,
	output pix_t      rd_pix
);

	pix_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign q_empty = (cnt_q == 2'd0);
	assign q_full  = (cnt_q == 2'd2);
	assign do_wr   = wr_vld && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_pix  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_pix;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// TGA run-length pixel decoder for 24- and 32-bit true-colour images.
// Input channel: one byte of the RLE pixel stream per transaction, taken
// at a clock edge with push high and full low. Result channel: one decoded
// pixel (colour, alpha, repeat count, image_done) per transaction, shown
// while empty is low and taken on pop. Configuration is a plain write
// port: index 0 selects 4-byte pixels with alpha, index 1 sets the pixel
// total of the image; write only while no transaction is in flight.
// Throughput is one byte per cycle while full is low. A pixel's result is
// queued the cycle after its last byte is accepted; header and colour
// bytes cause no result. The front parser and the pixel counter handle
// each byte as it is accepted, and a two-entry result queue decouples the
// two sides. When the receiver stalls, the queue fills and full rises
// once two results wait; input resumes the cycle after a pop.
// Reset clears the queue and the parser, and sets has_alpha to 0 and the
// pixel total to 1. After the result flagged image_done, the next byte is
// taken as the first packet header of a new image.
`default_nettype none
module tga_rle_pixel_decoder
	import trd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [ByteW-1:0]   data_byte,
	output logic                    empty,
	input  wire logic               pop,
	output logic [ByteW-1:0]        blue,
	output logic [ByteW-1:0]        green,
	output logic [ByteW-1:0]        red,
	output logic [ByteW-1:0]        alpha,
	output logic [ByteW-1:0]        repeat_count,
	output logic                    image_done,
	input  wire logic               wr_en,
	input  wire logic [CfgIdxW-1:0] wr_index,
	input  wire logic [CfgW-1:0]    wr_data
);

	logic byte_vld;
	logic pix_vld;
	pix_t pix;
	pix_t out_pix;
	logic q_full;

	assign full     = q_full;
	assign byte_vld = push && !q_full;

	trd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_vld (byte_vld),
		.byte_in  (data_byte),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pix_vld  (pix_vld),
		.pix      (pix)
	);

	trd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_vld  (pix_vld),
		.wr_pix  (pix),
		.rd_en   (pop),
		.q_empty (empty),
		.q_full  (q_full),
		.rd_pix  (out_pix)
	);

	assign blue         = out_pix.blue;
	assign green        = out_pix.green;
	assign red          = out_pix.red;
	assign alpha        = out_pix.alpha;
	assign repeat_count = out_pix.repeat_count;
	assign image_done   = out_pix.image_done;

endmodule
`default_nettype wire

// ===== rtl/core/trd_checker.sv =====
`default_nettype none
module trd_checker
	import trd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire logic             empty,
	input wire logic             pop,
	input wire logic [ByteW-1:0] blue,
	input wire logic [ByteW-1:0] green,
	input wire logic [ByteW-1:0] red,
	input wire logic [ByteW-1:0] alpha,
	input wire logic [ByteW-1:0] repeat_count,
	input wire logic             image_done
);

	// A result never counts for zero pixels or more than one run allows.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (repeat_count != '0) && (repeat_count <= MaxRepeat))
		else $error("repeat_count out of range");

	// A result only appears after an input transaction.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(empty) |-> $past(push && !full))
		else $error("result appeared without an input transaction");

	// A stalled result stays put.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(blue) && $stable(green) && $stable(red)
			&& $stable(alpha) && $stable(repeat_count) && $stable(image_done))
		else $error("stalled result changed");

	// Input is never refused while no result waits.
	a_no_false_full: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !full)
		else $error("full with no result waiting");

endmodule

bind tga_rle_pixel_decoder trd_checker u_trd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.blue         (blue),
	.green        (green),
	.red          (red),
	.alpha        (alpha),
	.repeat_count (repeat_count),
	.image_done   (image_done)
);
`default_nettype wire

// ===== verif/tga_rle_pixel_checker.sv =====
`timescale 1ns / 1ps
module tga_rle_pixel_checker
	import trd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [ByteW-1:0]   data_byte,
	input  logic               empty,
	input  logic               pop,
	input  logic [ByteW-1:0]   blue,
	input  logic [ByteW-1:0]   green,
	input  logic [ByteW-1:0]   red,
	input  logic [ByteW-1:0]   alpha,
	input  logic [ByteW-1:0]   repeat_count,
	input  logic               image_done,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [CfgW-1:0]    wr_data,
	output int                 mismatches,
	output int                 outstanding,
	output logic               image_start
);

	logic              alpha_on;
	logic [TotalW-1:0] image_pixels;
	logic              want_header;
	logic              run_mode;
	logic [7:0]        packet_left;
	logic [1:0]        byte_pos;
	logic [23:0]       color_acc;
	logic [TotalW-1:0] pixels_out;
	pix_t              expected_pixels[$];
	pix_t              oldest;
	int                err_count;

	assign mismatches = err_count;

	task automatic report(input string msg);
		err_count++;
		$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	task automatic start_image();
		want_header = 1'b1;
		run_mode    = 1'b0;
		packet_left = '0;
		byte_pos    = POS_BLUE;
		color_acc   = '0;
		pixels_out  = '0;
	endtask

	// Advances the decoder by one stream byte and queues the pixel it completes.
	task automatic decode_byte(input logic [7:0] b);
		pix_t              px;
		logic [8:0]        count;
		logic [TotalW-1:0] pixels_left;
		logic              pixel_end;
		if (want_header) begin
			run_mode    = b[7];
			packet_left = {1'b0, b[6:0]} + 8'd1;
			want_header = 1'b0;
			byte_pos    = POS_BLUE;
		end else begin
			pixel_end = (byte_pos == POS_ALPHA) || (byte_pos == POS_RED && !alpha_on);
			if (!pixel_end) begin
				color_acc[8*byte_pos +: 8] = b;
				byte_pos = byte_pos + 2'd1;
			end else begin
				px.blue  = color_acc[7:0];
				px.green = color_acc[15:8];
				if (byte_pos == POS_RED) begin
					px.red   = b;
					px.alpha = '0;
				end else begin
					// A fourth byte with alpha switched off closes the pixel unused.
					px.red   = color_acc[23:16];
					px.alpha = alpha_on ? b : 8'd0;
				end
				byte_pos = POS_BLUE;
				count = run_mode ? {1'b0, packet_left} : 9'd1;
				if (count == 0 || count > MaxRepeat)
					count = 9'd1;
				pixels_left = (image_pixels > pixels_out) ? image_pixels - pixels_out : 1;
				if (count > pixels_left)
					count = pixels_left[8:0];
				px.repeat_count = count[7:0];
				px.image_done   = (count == pixels_left);
				expected_pixels = {expected_pixels, px};
				if (px.image_done) begin
					start_image();
				end else begin
					pixels_out += count;
					if (run_mode) begin
						packet_left = '0;
						want_header = 1'b1;
					end else begin
						if (packet_left != 0)
							packet_left--;
						if (packet_left == 0)
							want_header = 1'b1;
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_on     = 1'b0;
			image_pixels = 1;
			start_image();
			expected_pixels.delete();
			outstanding <= 0;
			image_start <= 1'b1;
		end else begin
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					report("result transaction with no pixel expected");
				end else begin
					oldest = expected_pixels.pop_front();
					check_field("blue", blue, oldest.blue);
					check_field("green", green, oldest.green);
					check_field("red", red, oldest.red);
					check_field("alpha", alpha, oldest.alpha);
					check_field("repeat_count", repeat_count, oldest.repeat_count);
					check_field("image_done", {7'd0, image_done}, {7'd0, oldest.image_done});
				end
			end
			if (push && !full)
				decode_byte(data_byte);
			if (wr_en) begin
				case (wr_index)
					REG_HAS_ALPHA:   alpha_on = wr_data[0];
					REG_PIXEL_TOTAL: image_pixels = wr_data[TotalW-1:0];
					default: ;
				endcase
			end
			outstanding <= expected_pixels.size();
			image_start <= want_header && (pixels_out == 0);
		end
	end

endmodule

// ===== verif/tb_tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
module tb_tga_rle_pixel_decoder;
	import trd_pkg::*;

	// Indexes with no register behind them.
	localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [ByteW-1:0]   data_byte;
	logic               empty;
	logic               pop;
	logic [ByteW-1:0]   blue;
	logic [ByteW-1:0]   green;
	logic [ByteW-1:0]   red;
	logic [ByteW-1:0]   alpha;
	logic [ByteW-1:0]   repeat_count;
	logic               image_done;
	logic               wr_en;
	logic [CfgIdxW-1:0] wr_index;
	logic [CfgW-1:0]    wr_data;

	int   mismatches;
	int   outstanding;
	logic image_start;
	logic gaps_on;
	logic alpha_mode;
	int   stall_left;
	int   bytes_sent;
	int   image_size;

	tga_rle_pixel_decoder dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .data_byte(data_byte),
		.empty(empty), .pop(pop), .blue(blue), .green(green), .red(red), .alpha(alpha),
		.repeat_count(repeat_count), .image_done(image_done),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	tga_rle_pixel_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .data_byte(data_byte),
		.empty(empty), .pop(pop), .blue(blue), .green(green), .red(red), .alpha(alpha),
		.repeat_count(repeat_count), .image_done(image_done),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.mismatches(mismatches), .outstanding(outstanding), .image_start(image_start)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tga_rle_pixel_decoder: mismatch");
		$finish;
	end

	// Receiver side: pops by default, stalls in short random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			pop <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			pop <= 1'b1;
		end
	end

	// Returns at the edge where the byte transaction is accepted.
	task automatic send_byte(input logic [7:0] b);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_pixel();
		repeat (alpha_mode ? 4 : 3)
			send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_alpha(input logic on);
		logic [CfgW-1:0] value;
		value = $urandom();
		value[0] = on;
		write_reg(REG_HAS_ALPHA, value);
		alpha_mode = on;
	endtask

	// Holds input back until every predicted pixel has been taken.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A stream of packets that covers at least the image size; a run packet or,
	// when broken, a literal packet may run past the end of the image.
	task automatic send_image(input int pixels, input logic broken);
		int   left_px;
		int   n;
		logic run;
		left_px = pixels;
		while (left_px > 0) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
			run = 1'($urandom_range(0, 1));
			if (!run && n > left_px && !broken)
				n = left_px;
			send_byte({run, 7'(n - 1)});
			if (run)
				send_pixel();
			else
				repeat (n) send_pixel();
			left_px -= n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		gaps_on = 1'b0;
		alpha_mode = 1'b0;
		bytes_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		gaps_on <= 1'b1;
		@(posedge clk);

		// Reset registers: a 128-pixel run is clipped to the single pixel.
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);

		settle();
		write_reg(REG_PIXEL_TOTAL, 32'h0001_FFFE);
		write_alpha(1'b1);
		write_reg(REG_PIXEL_TOTAL, 32'd0);
		// A zero pixel total lets the first pixel finish the image.
		send_byte(8'h85);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0F);
		send_byte(8'hF0);

		settle();
		write_alpha(1'b0);
		write_reg(REG_PIXEL_TOTAL, 32'hFFFE_0001);
		write_reg(REG_SPARE_A, $urandom());
		write_reg(REG_SPARE_B, $urandom());
		send_byte(8'hFF);
		send_byte(8'hA5);
		send_byte(8'h3C);
		send_byte(8'hC3);
		// Total dropped below the pixels already out: next pixel ends the image.
		settle();
		write_reg(REG_PIXEL_TOTAL, 32'd5);
		send_byte(8'h00);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h56);

		// Alpha switched off in the middle of one pixel and back on in the next.
		settle();
		write_alpha(1'b1);
		write_reg(REG_PIXEL_TOTAL, 32'd2);
		send_byte(8'h01);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		settle();
		write_alpha(1'b0);
		send_byte(8'h44);
		send_byte(8'h55);
		send_byte(8'h66);
		settle();
		write_alpha(1'b1);
		send_byte(8'h77);
		send_byte(8'h88);

		while (bytes_sent < 760) begin
			if (bytes_sent > 640)
				gaps_on <= 1'b0;
			settle();
			if (!image_start) begin
				// A total of one lets any completed pixel close the stray image.
				write_reg(REG_PIXEL_TOTAL, 32'd1);
				while (!image_start) begin
					send_byte(8'($urandom_range(0, 255)));
					push <= 1'b0;
					@(posedge clk);
				end
			end
			write_alpha(1'($urandom_range(0, 1)));
			image_size = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 400)
				: $urandom_range(1, 30);
			write_reg(REG_PIXEL_TOTAL, image_size);
			send_image(image_size, $urandom_range(0, 7) == 0);
		end

		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tga_rle_pixel_decoder: match");
		else
			$display("tga_rle_pixel_decoder: mismatch");
		$finish;
	end

endmodule
